// ----- src/wkt_pkg.sv -----
// ----------------------------------------------------------------------------
// wkt_pkg
// Shared types and constants for the Wiegand 4-bit keypad transmitter.
// ----------------------------------------------------------------------------
package wkt_pkg;

   // number of Wiegand interfaces wired up (1..4); ports at or above are refused
   localparam int PORTS = 4;

   localparam int KEY_W      = 8;
   localparam int PORT_W     = 2;
   localparam int CODE_W     = 4;
   localparam int BITCNT_W   = 2;
   localparam int LINES_W    = 4;
   localparam int PULSE_W    = 10;
   localparam int BIT_GAP_W  = 16;
   localparam int KEY_GAP_W  = 18;
   localparam int CNT_W      = 18;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 18;

   localparam logic [PULSE_W-1:0]   PULSE_RESET   = 10'd100;
   localparam logic [BIT_GAP_W-1:0] BIT_GAP_RESET = 16'd2000;
   localparam logic [KEY_GAP_W-1:0] KEY_GAP_RESET = 18'd200000;

   // ASCII keys
   localparam logic [KEY_W-1:0] ASCII_0       = 8'h30;
   localparam logic [KEY_W-1:0] ASCII_9       = 8'h39;
   localparam logic [KEY_W-1:0] ASCII_STAR    = 8'h2A;
   localparam logic [KEY_W-1:0] ASCII_PERCENT = 8'h25;

   localparam logic [CODE_W-1:0] CODE_STAR    = 4'b1010;
   localparam logic [CODE_W-1:0] CODE_PERCENT = 4'b1011;

   localparam logic [BITCNT_W-1:0] LAST_BIT = 2'd3;

   localparam logic OP_TICK = 1'b0;
   localparam logic OP_KEY  = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_PULSE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BIT_GAP = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_GAP = 2'd2;

   typedef enum logic [1:0] {
      PH_IDLE   = 2'd0,
      PH_PULSE  = 2'd1,
      PH_GAP    = 2'd2,
      PH_KEYGAP = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_INVALID = 2'd1,
      ST_BUSY    = 2'd2
   } status_type;

   typedef struct packed {
      logic [PULSE_W-1:0]   pulse_ticks;
      logic [BIT_GAP_W-1:0] bit_gap_ticks;
      logic [KEY_GAP_W-1:0] key_gap_ticks;
   } timing_cfg_type;

   typedef struct packed {
      logic              valid;
      logic [CODE_W-1:0] code;
   } key_info_type;

   typedef struct packed {
      logic [LINES_W-1:0] d0_lines;
      logic [LINES_W-1:0] d1_lines;
      logic               busy;
      status_type         status;
   } result_type;

endpackage

// ----- src/wkt_key_decode.sv -----
// ----------------------------------------------------------------------------
// wkt_key_decode
// Maps a key character and port number to a 4-bit code plus a valid flag.
// ----------------------------------------------------------------------------
module wkt_key_decode
   import wkt_pkg::*;
(
   input  logic [KEY_W-1:0]  key_code,
   input  logic [PORT_W-1:0] port,
   output key_info_type      key_info
);

   logic [KEY_W-1:0] digit;
   logic             port_ok;

   assign digit   = key_code - ASCII_0;
   assign port_ok = (32'(port) < PORTS);

   always_comb begin
      key_info.valid = 1'b0;
      key_info.code  = '0;
      unique if (key_code >= ASCII_0 && key_code <= ASCII_9) begin
         key_info.valid = port_ok;
         key_info.code  = digit[CODE_W-1:0];
      end else if (key_code == ASCII_STAR) begin
         key_info.valid = port_ok;
         key_info.code  = CODE_STAR;
      end else if (key_code == ASCII_PERCENT) begin
         key_info.valid = port_ok;
         key_info.code  = CODE_PERCENT;
      end else begin
         key_info.valid = 1'b0;
      end
   end

endmodule

// ----- src/wkt_engine.sv -----
// ----------------------------------------------------------------------------
// wkt_engine
// Bit timing state machine; one word per call, result reflects the new state.
// ----------------------------------------------------------------------------
module wkt_engine
   import wkt_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic              op,
   input  logic [PORT_W-1:0] port,
   input  key_info_type      key_info,
   input  timing_cfg_type    cfg,
   output result_type        result
);

   phase_type             phase_ff, phase_in;
   logic [BITCNT_W-1:0]   bit_count_ff, bit_count_in;
   logic [CODE_W-1:0]     code_bits_ff, code_bits_in;
   logic [PORT_W-1:0]     active_port_ff, active_port_in;
   logic [CNT_W-1:0]      countdown_ff, countdown_in;
   status_type            item_status;

   logic [CNT_W-1:0] pulse_load, gap_load, cnt_dec;

   // zero pulse / bit-gap settings count as one tick
   assign pulse_load = (cfg.pulse_ticks == '0) ? CNT_W'(1) : CNT_W'(cfg.pulse_ticks);
   assign gap_load   = (cfg.bit_gap_ticks == '0) ? CNT_W'(1) : CNT_W'(cfg.bit_gap_ticks);
   assign cnt_dec    = (countdown_ff != '0) ? countdown_ff - CNT_W'(1) : '0;

   // next state
   always_comb begin
      phase_in       = phase_ff;
      bit_count_in   = bit_count_ff;
      code_bits_in   = code_bits_ff;
      active_port_in = active_port_ff;
      countdown_in   = countdown_ff;
      item_status    = ST_OK;
      if (op == OP_TICK) begin
         if (phase_ff != PH_IDLE) begin
            countdown_in = cnt_dec;
            if (cnt_dec == '0) begin
               unique case (phase_ff)
                  PH_PULSE: begin
                     phase_in     = PH_GAP;
                     countdown_in = gap_load;
                  end
                  PH_GAP: begin
                     if (bit_count_ff == LAST_BIT) begin
                        bit_count_in = '0;
                        if (cfg.key_gap_ticks == '0) begin
                           phase_in = PH_IDLE;
                        end else begin
                           phase_in     = PH_KEYGAP;
                           countdown_in = CNT_W'(cfg.key_gap_ticks);
                        end
                     end else begin
                        bit_count_in = bit_count_ff + BITCNT_W'(1);
                        phase_in     = PH_PULSE;
                        countdown_in = pulse_load;
                     end
                  end
                  PH_KEYGAP: phase_in = PH_IDLE;
                  PH_IDLE:   phase_in = PH_IDLE;
                  default:   phase_in = PH_IDLE;
               endcase
            end
         end
      end else if (phase_ff != PH_IDLE) begin
         item_status = ST_BUSY;
      end else if (!key_info.valid) begin
         item_status = ST_INVALID;
      end else begin
         code_bits_in   = key_info.code;
         active_port_in = port;
         bit_count_in   = '0;
         phase_in       = PH_PULSE;
         countdown_in   = pulse_load;
      end
   end

   // outputs, taken from the state after this word
   logic              cur_bit;
   logic [LINES_W-1:0] port_mask;

   always_comb begin
      cur_bit   = code_bits_in[LAST_BIT - bit_count_in];
      port_mask = LINES_W'(1) << active_port_in;
      result.d0_lines = '1;
      result.d1_lines = '1;
      if (phase_in == PH_PULSE) begin
         if (cur_bit) begin
            result.d1_lines = ~port_mask;
         end else begin
            result.d0_lines = ~port_mask;
         end
      end
      result.busy   = (phase_in != PH_IDLE);
      result.status = item_status;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         bit_count_ff   <= '0;
         code_bits_ff   <= '0;
         active_port_ff <= '0;
         countdown_ff   <= '0;
      end else if (step) begin
         phase_ff       <= phase_in;
         bit_count_ff   <= bit_count_in;
         code_bits_ff   <= code_bits_in;
         active_port_ff <= active_port_in;
         countdown_ff   <= countdown_in;
      end
   end

endmodule

// ----- src/wiegand_keypad_transmitter_core.sv -----
// ----------------------------------------------------------------------------
// wiegand_keypad_transmitter_core
// Wiegand 4-bit keypad transmitter for up to four interfaces, tick driven.
// ----------------------------------------------------------------------------
// Usage:
//  - req channel (valid/ready): req_op = 0 is one time tick, req_op = 1 asks to
//    send req_key_code ('0'..'9', '*', '%') on interface req_port.
//  - rsp channel (valid/ready): exactly one word per req word, showing the
//    D0/D1 line levels (low active, bit n = port n), busy and status
//    (ok, invalid key, busy refused) after that word took effect.
//  - Output is registered: a word accepted at edge N shows on rsp after N.
//  - Throughput is one word per cycle unless rsp stalls; the state update of
//    the bit timer is a single decrement/compare pass, state to result reg.
//  - req_ready stays high while the result register is empty or being
//    drained; a stalled rsp holds its word and blocks only further req words.
//  - csr_we writes pulse / bit-gap / key-gap tick counts by csr_index; write
//    only while idle. Unknown indexes are ignored.
//  - Reset (synchronous): idle, rsp empty, timing registers back
//    to 100 / 2000 / 200000 ticks.
// ----------------------------------------------------------------------------
module wiegand_keypad_transmitter_core
   import wkt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_op,
   input  logic [KEY_W-1:0]      req_key_code,
   input  logic [PORT_W-1:0]     req_port,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [LINES_W-1:0]    rsp_d0_lines,
   output logic [LINES_W-1:0]    rsp_d1_lines,
   output logic                  rsp_busy_res,
   output logic [1:0]            rsp_status,
   // configuration
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   timing_cfg_type cfg_ff;
   key_info_type   key_info;
   result_type     result;
   result_type     result_ff;
   logic           rsp_valid_ff;
   logic           accept;

   // result register frees up in the same cycle it is drained
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // timing registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pulse_ticks   <= PULSE_RESET;
         cfg_ff.bit_gap_ticks <= BIT_GAP_RESET;
         cfg_ff.key_gap_ticks <= KEY_GAP_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PULSE: begin
               cfg_ff.pulse_ticks <= csr_wdata[PULSE_W-1:0];
            end
            CSR_BIT_GAP: begin
               cfg_ff.bit_gap_ticks <= csr_wdata[BIT_GAP_W-1:0];
            end
            CSR_KEY_GAP: begin
               cfg_ff.key_gap_ticks <= csr_wdata[KEY_GAP_W-1:0];
            end
            default: ;
         endcase
      end
   end

   wkt_key_decode u_decode (
      .key_code (req_key_code),
      .port     (req_port),
      .key_info (key_info)
   );

   // state advances only on an accepted word
   wkt_engine u_engine (
      .clock    (clock),
      .reset    (reset),
      .step     (accept),
      .op       (req_op),
      .port     (req_port),
      .key_info (key_info),
      .cfg      (cfg_ff),
      .result   (result)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         result_ff <= result;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_d0_lines = result_ff.d0_lines;
   assign rsp_d1_lines = result_ff.d1_lines;
   assign rsp_busy_res = result_ff.busy;
   assign rsp_status   = result_ff.status;

endmodule
